// ----- hdl/qpht_pkg.sv -----
// Shared types and constants for the quadratic-probing hash table unit.
// Depends on nothing; used by quadratic_probe_hash_table_unit and its testbench.
`default_nettype none

package qpht_pkg;

  // Field widths.
  localparam int CFG_W    = 7;
  localparam int KEY_W    = 31;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;

  // Default table depth and the reset value of the size register.
  localparam int             DEPTH_DEF  = 64;
  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  // One input beat.
  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/qpht_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module qpht_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/quadratic_probe_hash_table_unit.sv -----
// Quadratic-probing hash table: sequencer, shared reduce unit and key RAM.
// Depends on qpht_pkg and qpht_ram.
//
//  channel | direction | handshake        | beat
//  in_     | in        | in_valid/in_stall | qpht_pkg::in_item_t (command, key)
//  out_    | out       | out_valid/out_stall | qpht_pkg::out_item_t (status, slot)
//  cfg_    | in        | cfg_valid/cfg_ready | table_size, 7 bits
//
// An item first reduces the key to its home slot (one remainder bit a cycle),
// then takes one probe after another (RAM read, then compare), then hands over
// the result; an item takes from 1 up to the size in use probes.
// The shared compare-and-subtract unit and the one RAM read port keep these steps in sequence.
// Reset clears the occupancy flags at once; there is no clearing pass.
// A stalled result waits in the output register; the next item may be taken
// meanwhile and holds in its last state until the output register is free.
`default_nettype none

module quadratic_probe_hash_table_unit #(
  parameter int DEPTH = qpht_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire qpht_pkg::in_item_t            in_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      qpht_pkg::out_item_t           out_data,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [qpht_pkg::CFG_W-1:0]    cfg_data
);

  // Largest size in use, slot index width, RAM address width, unit width, key bit index width.
  localparam int SMAX = (DEPTH < 127) ? DEPTH : 127;
  localparam int PW   = $clog2(SMAX);
  localparam int AW   = $clog2(DEPTH);
  localparam int UW   = qpht_pkg::CFG_W + 1;
  localparam int BW   = $clog2(qpht_pkg::KEY_W);
  localparam logic [qpht_pkg::CFG_W-1:0] SMAX_V = qpht_pkg::CFG_W'(SMAX);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_PUSH
  } state_t;

  state_t                         state_r, state_nxt;
  logic [qpht_pkg::CFG_W-1:0]     size_r, size_nxt;
  logic                           cmd_r, cmd_nxt;
  logic [qpht_pkg::KEY_W-1:0]     key_r, key_nxt;
  logic [PW-1:0]                  p_r, p_nxt;
  logic [PW-1:0]                  d_r, d_nxt;
  logic [qpht_pkg::CFG_W-1:0]     cnt_r, cnt_nxt;
  logic [BW-1:0]                  bit_r, bit_nxt;
  logic [SMAX-1:0]                used_r, used_nxt;
  qpht_pkg::out_item_t            res_r, res_nxt;
  qpht_pkg::out_item_t            out_r, out_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic [qpht_pkg::CFG_W-1:0]     size;
  logic [UW-1:0]                  unit_a;
  logic [UW-1:0]                  unit_y;
  logic [PW-1:0]                  unit_res;
  logic                           wr_en;
  logic                           rd_en;
  logic [qpht_pkg::KEY_W-1:0]     rd_key;
  logic                           slot_used;
  logic                           last_probe;
  logic                           out_free;

  // Size in use: zero counts as one, anything above the table depth as the depth.
  always_comb begin
    if (size_r == '0) begin
      size = qpht_pkg::CFG_W'(1);
    end else if (size_r > SMAX_V) begin
      size = SMAX_V;
    end else begin
      size = size_r;
    end
  end

  // Shared reduce unit: one compare and subtract of the size, operand chosen by state.
  // Every operand stays below twice the size (but the unused step update at size one), so one subtraction is enough.
  always_comb begin
    case (state_r)
      S_DIV:   unit_a = UW'({p_r, key_r[bit_r]});
      S_READ:  unit_a = UW'(d_r) + UW'(2);
      S_CHECK: unit_a = UW'(p_r) + UW'(d_r);
      default: unit_a = '0;
    endcase
    unit_y   = (unit_a >= UW'(size)) ? (unit_a - UW'(size)) : unit_a;
    unit_res = PW'(unit_y);
  end

  // Key store.
  qpht_ram #(
    .WIDTH (qpht_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(p_r)),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (AW'(p_r)),
    .rd_data (rd_key)
  );

  assign slot_used  = used_r[p_r];
  assign last_probe = (cnt_r == (size - qpht_pkg::CFG_W'(1)));
  assign out_free   = !out_valid_r || !out_stall;
  assign rd_en      = (state_r == S_READ);
  assign wr_en      = (state_r == S_CHECK) && (cmd_r == qpht_pkg::CMD_INSERT) && !slot_used;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer: reduce the key, then read and check one probe at a time.
  always_comb begin
    state_nxt     = state_r;
    size_nxt      = size_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    used_nxt      = used_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    // A taken result beat frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      size_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          key_nxt   = in_data.key;
          p_nxt     = '0;
          bit_nxt   = BW'(qpht_pkg::KEY_W - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring remainder, most significant key bit first.
        p_nxt = unit_res;
        if (bit_r == '0) begin
          cnt_nxt   = '0;
          // Step starts at minus one so that the first update gives one.
          d_nxt     = PW'(size - qpht_pkg::CFG_W'(1));
          state_nxt = S_READ;
        end else begin
          bit_nxt = bit_r - BW'(1);
        end
      end
      S_READ: begin
        // Step to the next probe is 2*i+1 modulo the size.
        d_nxt     = unit_res;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_PUSH;
        if (cmd_r == qpht_pkg::CMD_INSERT) begin
          if (!slot_used) begin
            used_nxt[p_r] = 1'b1;
            res_nxt       = '{status: qpht_pkg::ST_INSERTED, slot: qpht_pkg::SLOT_W'(p_r)};
          end else if (last_probe) begin
            res_nxt = '{status: qpht_pkg::ST_FULL, slot: '0};
          end else begin
            state_nxt = S_READ;
          end
        end else begin
          if (!slot_used) begin
            res_nxt = '{status: qpht_pkg::ST_MISSING, slot: '0};
          end else if (rd_key == key_r) begin
            res_nxt = '{status: qpht_pkg::ST_FOUND, slot: qpht_pkg::SLOT_W'(p_r)};
          end else if (last_probe) begin
            res_nxt = '{status: qpht_pkg::ST_MISSING, slot: '0};
          end else begin
            state_nxt = S_READ;
          end
        end
        if (state_nxt == S_READ) begin
          p_nxt   = unit_res;
          cnt_nxt = cnt_r + qpht_pkg::CFG_W'(1);
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, size, occupancy flags, working registers and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= qpht_pkg::SIZE_RESET;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    p_r   <= p_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    bit_r <= bit_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  // A key is only ever written into an empty slot by an insert.
  a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (cmd_r == qpht_pkg::CMD_INSERT) && !slot_used)
    else $error("key written over an occupied slot");

  // Probes stay inside the size in use.
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (qpht_pkg::CFG_W'(p_r) < size) && (cnt_r < size))
    else $error("probe outside the table in use");

  // A taken result beat is not shown again unless a new result is loaded.
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && (state_r != S_PUSH)) |=> !out_valid_r)
    else $error("result beat repeated");

  // An accepted item starts the key reduction.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DIV))
    else $error("accepted item did not start");

endmodule

`default_nettype wire

// ----- tb/tb_quadratic_probe_hash_table_unit.sv -----
// Self-checking testbench for quadratic_probe_hash_table_unit: directed and random inserts
// and searches across table sizes, each result checked against a shadow hash table.
// Depends on qpht_pkg and the RTL of the unit only.

module tb_quadratic_probe_hash_table_unit;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int ITEM_TARGET    = 1200;
  localparam int CALM_FROM      = 1050;

  logic clk;
  logic rst_n = 1'b0;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  qpht_pkg::in_item_t             in_data  = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  qpht_pkg::out_item_t            out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [qpht_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Shadow copy of the table and of the size register.
  logic                           shadow_used [qpht_pkg::DEPTH_DEF];
  logic [qpht_pkg::KEY_W-1:0]     shadow_key  [qpht_pkg::DEPTH_DEF];
  logic [qpht_pkg::CFG_W-1:0]     shadow_size = qpht_pkg::SIZE_RESET;

  qpht_pkg::in_item_t             beats_to_send[$];
  qpht_pkg::out_item_t            pending_results[$];
  logic [qpht_pkg::KEY_W-1:0]     stored_keys[$];

  int   errors     = 0;
  int   items_made = 0;
  int   idle_mode  = 0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  logic in_took    = 1'b0;
  qpht_pkg::out_item_t predicted;

  quadratic_probe_hash_table_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Walk the quadratic probe sequence for one beat, updating the shadow table.
  task automatic probe_table(input qpht_pkg::in_item_t beat, output qpht_pkg::out_item_t res);
    int      sz;
    int      home;
    int      s;
    int      i;
    logic    done;
    qpht_pkg::status_t st;
    logic [qpht_pkg::SLOT_W-1:0] where;
    sz = int'(shadow_size);
    if (sz == 0) sz = 1;
    if (sz > qpht_pkg::DEPTH_DEF) sz = qpht_pkg::DEPTH_DEF;
    home  = int'(beat.key % 31'(sz));
    st    = (beat.command == qpht_pkg::CMD_INSERT) ? qpht_pkg::ST_FULL : qpht_pkg::ST_MISSING;
    where = '0;
    done  = 1'b0;
    for (i = 0; i < sz && !done; i++) begin
      s = (home + i * i) % sz;
      if (beat.command == qpht_pkg::CMD_INSERT) begin
        if (!shadow_used[s]) begin
          shadow_used[s] = 1'b1;
          shadow_key[s]  = beat.key;
          st    = qpht_pkg::ST_INSERTED;
          where = s[qpht_pkg::SLOT_W-1:0];
          done  = 1'b1;
        end
      end else if (!shadow_used[s]) begin
        done = 1'b1;
      end else if (shadow_key[s] == beat.key) begin
        st    = qpht_pkg::ST_FOUND;
        where = s[qpht_pkg::SLOT_W-1:0];
        done  = 1'b1;
      end
    end
    res.status = st;
    res.slot   = where;
  endtask

  // Input side: note each accepted beat and predict its result.
  always @(posedge clk) begin
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      probe_table(in_data, predicted);
      pending_results.push_back(predicted);
    end
  end

  // Input driver: hold a stalled beat, otherwise idle in bursts or present the next one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (beats_to_send.size() == 0) begin
      in_valid <= 1'b0;
    end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 15 : 3) == 0) begin
      gap_left <= $urandom_range(1, 19) - 1;
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_data  <= beats_to_send.pop_front();
    end
  end

  // Result side: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    qpht_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d", out_data.status, out_data.slot);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, out_data.slot);
          errors++;
        end
      end
    end
  end

  // Result stall in random bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 15 : 3) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles in which no beat of any channel is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_quadratic_probe_hash_table_unit: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_beat(input logic cmd, input logic [qpht_pkg::KEY_W-1:0] key);
    qpht_pkg::in_item_t beat;
    beat.command = cmd;
    beat.key     = key;
    beats_to_send.push_back(beat);
    items_made++;
  endtask

  // Wait until no beat is in flight and every predicted result has come back.
  task automatic wait_drained();
    @(posedge clk);
    while (in_valid || beats_to_send.size() != 0 || pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Change the table size once the unit is idle.
  task automatic write_table_size(input logic [qpht_pkg::CFG_W-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_size = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly searches and re-inserts of keys already stored, plus fresh keys.
  task automatic queue_random_beat();
    int r;
    logic [qpht_pkg::KEY_W-1:0] key;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) key = qpht_pkg::KEY_W'($urandom);
    else key = qpht_pkg::KEY_W'($urandom_range(0, 255));
    if (r < 15) begin
      queue_beat(qpht_pkg::CMD_INSERT, key);
      stored_keys.push_back(key);
    end else if (r < 25 && stored_keys.size() != 0) begin
      queue_beat(qpht_pkg::CMD_INSERT,
                 stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    end else if (r < 75 && stored_keys.size() != 0) begin
      queue_beat(qpht_pkg::CMD_SEARCH,
                 stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    end else begin
      queue_beat(qpht_pkg::CMD_SEARCH, key);
    end
  endtask

  initial begin
    int i;
    int n;
    int r;
    logic [qpht_pkg::CFG_W-1:0] sz;
    for (i = 0; i < qpht_pkg::DEPTH_DEF; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset size: key extremes, duplicates, a collision.
    idle_mode = 1;
    queue_beat(qpht_pkg::CMD_INSERT, '0);
    queue_beat(qpht_pkg::CMD_INSERT, '1);
    queue_beat(qpht_pkg::CMD_SEARCH, '0);
    queue_beat(qpht_pkg::CMD_SEARCH, '1);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'd5);
    queue_beat(qpht_pkg::CMD_INSERT, '0);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'd64);
    queue_beat(qpht_pkg::CMD_INSERT, 31'd64);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'd64);

    // Size zero behaves as one slot: full table and an exhausted search.
    write_table_size(7'd0);
    queue_beat(qpht_pkg::CMD_INSERT, 31'd123);
    queue_beat(qpht_pkg::CMD_SEARCH, '0);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'd7);
    queue_beat(qpht_pkg::CMD_SEARCH, '1);

    // Oversized setting is clamped to the full depth.
    write_table_size(7'd127);
    queue_beat(qpht_pkg::CMD_INSERT, 31'h2AAAAAAA);
    queue_beat(qpht_pkg::CMD_INSERT, 31'h55555555);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'h55555555);

    // Size four: the probe sequence covers only two slots, so full comes early.
    write_table_size(7'd4);
    queue_beat(qpht_pkg::CMD_INSERT, 31'd2);
    queue_beat(qpht_pkg::CMD_INSERT, 31'd2);
    queue_beat(qpht_pkg::CMD_INSERT, 31'd2);
    queue_beat(qpht_pkg::CMD_SEARCH, 31'd3);

    // Random phases, each at its own table size and idling mode.
    while (items_made < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      case (r)
        0: begin
          sz = 7'd0;
        end
        1: begin
          sz = qpht_pkg::CFG_W'($urandom_range(65, 127));
        end
        2: begin
          sz = 7'd1;
        end
        3: begin
          sz = 7'd64;
        end
        default: begin
          sz = qpht_pkg::CFG_W'($urandom_range(2, 64));
        end
      endcase
      write_table_size(sz);
      idle_mode = (items_made >= CALM_FROM) ? 0 : $urandom_range(0, 2);
      n = $urandom_range(20, 60);
      for (i = 0; i < n; i++) begin
        queue_random_beat();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_quadratic_probe_hash_table_unit: clean");
    end else begin
      $display("tb_quadratic_probe_hash_table_unit: errors");
    end
    $finish;
  end

endmodule
